// ===== rtl/wmva_pkg.sv =====
// ---------------------------------------------------------------------------
// wmva_pkg
// Shared types and constants for the weighted mean / variance accumulator.
// ---------------------------------------------------------------------------
package wmva_pkg;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_ACCUM = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   localparam logic [1:0] CSR_MIN_VARIANCE = 2'd0;
   localparam logic [1:0] CSR_USE_PRIOR    = 2'd1;
   localparam logic [1:0] CSR_PRIOR_ALPHA  = 2'd2;

   localparam int VAR_BITS = 24;

   typedef struct packed {
      logic [1:0]  op;
      logic [2:0]  cluster;
      logic [2:0]  feature;
      logic [12:0] weight;
      logic [15:0] reading;
      logic        add_weight;
      logic [23:0] prior_beta;
   } req_type;

   typedef struct packed {
      logic [15:0] mean;
      logic [23:0] variance;
   } rsp_type;

endpackage

// ===== rtl/wmva_ram.sv =====
// ---------------------------------------------------------------------------
// wmva_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ---------------------------------------------------------------------------
module wmva_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/wmva_div.sv =====
// ---------------------------------------------------------------------------
// wmva_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module wmva_div #(
   parameter int DVW = 60,
   parameter int DSW = 30
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [DVW-1:0] dividend,
   input  logic [DSW-1:0] divisor,
   output logic           done,
   output logic [DVW-1:0] quotient
);

   localparam int CW = $clog2(DVW + 1);

   logic           busy_ff;
   logic           done_ff;
   logic [CW-1:0]  cnt_ff;
   logic [DVW-1:0] dvd_ff;
   logic [DSW-1:0] dsr_ff;
   logic [DSW-1:0] rem_ff;
   logic [DSW:0]   trial;
   logic [DSW:0]   diff;
   logic           ge;

   assign trial = {rem_ff, dvd_ff[DVW-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign ge    = (trial >= {1'b0, dsr_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(DVW);
            dvd_ff  <= dividend;
            dsr_ff  <= divisor;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            dvd_ff <= {dvd_ff[DVW-2:0], ge};
            rem_ff <= ge ? diff[DSW-1:0] : trial[DSW-1:0];
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

// ===== rtl/weighted_mean_variance_accumulator.sv =====
// ---------------------------------------------------------------------------
// weighted_mean_variance_accumulator
// Flow: an accumulate passes through S_ACC1 and S_ACC2, a clear sweeps every
// pair entry, and a query runs the shared bit-serial divider for the mean and
// the second moment, plus once more for the numerator with the prior form.
// Throughput: one request at a time; the result register frees the input side.
// Reset: synchronous; the block then sweeps both sum memories to zero
// before it accepts a request.
// ---------------------------------------------------------------------------
module weighted_mean_variance_accumulator
   import wmva_pkg::*;
#(
   parameter int CLUSTERS          = 8,
   parameter int FEATURES          = 8,
   parameter int SAMPLE_COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   // Accumulator widths follow the sample count budget.
   localparam int WT_BITS = 13 + SAMPLE_COUNT_BITS;
   localparam int S1_BITS = 28 + SAMPLE_COUNT_BITS;
   localparam int S2_BITS = 44 + SAMPLE_COUNT_BITS;
   localparam int PRW     = S1_BITS + S2_BITS;
   localparam int PAIRS   = CLUSTERS * FEATURES;
   localparam int PW      = (PAIRS > 1) ? $clog2(PAIRS) : 1;
   localparam int CW      = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
   // The divider dividend covers the second moment and every shifted numerator.
   localparam int DVW     = S2_BITS;
   // The divisor covers the weight total and the prior denominator.
   localparam int DSW     = ((WT_BITS > 22) ? WT_BITS : 22) + 1;
   localparam int SSW     = WT_BITS + 12;
   localparam int NSW     = WT_BITS + 13;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_ACC1, S_ACC2, S_QRD, S_QDIV1, S_QDIV2,
      S_QMSQ, S_QVAR, S_QSS, S_QNUM, S_QDIV3, S_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [PW-1:0]    clr_cnt_ff, clr_cnt_in;
   req_type          req_ff, req_in;
   logic [PW-1:0]    pair_ff, pair_in;
   logic [CW-1:0]    clus_ff, clus_in;
   logic [28:0]      wr_ff, wr_in;
   logic [44:0]      wrr_ff, wrr_in;
   logic [S2_BITS-1:0] s2_ff, s2_in;
   logic [WT_BITS-1:0] n_ff, n_in;
   logic [31:0]      m24_ff, m24_in;
   logic [DVW-1:0]   e24_ff, e24_in;
   logic [39:0]      msq_ff, msq_in;
   logic [23:0]      v12_ff, v12_in;
   logic [SSW-1:0]   ss_ff, ss_in;
   logic [15:0]      mean_ff, mean_in;
   logic [23:0]      var_ff, var_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   // Configuration registers.
   logic [23:0]      min_variance_ff;
   logic             use_prior_ff;
   logic [15:0]      prior_alpha_ff;

   // Memory ports.
   logic             pram_we, wram_we;
   logic [PW-1:0]    pram_waddr, pram_raddr;
   logic [CW-1:0]    wram_waddr, wram_raddr;
   logic [PRW-1:0]   pram_wdata, pram_rdata;
   logic [WT_BITS-1:0] wram_wdata, wram_rdata;

   // Divider ports.
   logic             div_start, div_done;
   logic [DVW-1:0]   div_dividend, div_q;
   logic [DSW-1:0]   div_divisor;

   logic             req_hit;
   logic [PW-1:0]    pair_req;
   logic [CW-1:0]    clus_req;
   logic [S1_BITS-1:0] s1_cur;
   logic [S2_BITS-1:0] s2_cur;
   logic [S1_BITS:0] s1_sum;
   logic [S2_BITS:0] s2_sum;
   logic [WT_BITS:0] wt_sum;
   logic [WT_BITS-1:0] n_floor;
   logic [DVW-1:0]   v24;
   logic [63:0]      m24_sq;
   logic [WT_BITS+23:0] ss_prod;
   logic [NSW-1:0]   num_sum;
   logic [23:0]      q_sat24;
   logic             prior_on;

   wmva_ram #(.WIDTH(PRW), .DEPTH(PAIRS)) u_pair_ram (
      .clock (clock),
      .we    (pram_we),
      .waddr (pram_waddr),
      .wdata (pram_wdata),
      .raddr (pram_raddr),
      .rdata (pram_rdata)
   );

   wmva_ram #(.WIDTH(WT_BITS), .DEPTH(CLUSTERS)) u_weight_ram (
      .clock (clock),
      .we    (wram_we),
      .waddr (wram_waddr),
      .wdata (wram_wdata),
      .raddr (wram_raddr),
      .rdata (wram_rdata)
   );

   wmva_div #(.DVW(DVW), .DSW(DSW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   // Index decode for the request at the port. Out-of-range pairs never
   // touch the memories.
   assign req_hit  = (32'(req_data.cluster) < CLUSTERS) &&
                     (32'(req_data.feature) < FEATURES);
   assign pair_req = PW'(32'(req_data.cluster) * FEATURES + 32'(req_data.feature));
   assign clus_req = CW'(req_data.cluster);

   // Reads are issued at accept time from the port, then held on the
   // latched address so the registered read data stays put.
   assign pram_raddr = (state_ff == S_IDLE) ? pair_req : pair_ff;
   assign wram_raddr = (state_ff == S_IDLE) ? clus_req : clus_ff;

   assign s1_cur  = pram_rdata[S1_BITS-1:0];
   assign s2_cur  = pram_rdata[PRW-1:S1_BITS];
   assign n_floor = (wram_rdata == '0) ? WT_BITS'(1) : wram_rdata;

   // Saturating sums; stored values never exceed their all-ones limit.
   assign s1_sum = {1'b0, s1_cur} + (S1_BITS+1)'(wr_ff);
   assign s2_sum = {1'b0, s2_cur} + (S2_BITS+1)'(wrr_ff);
   assign wt_sum = {1'b0, wram_rdata} + (WT_BITS+1)'(req_ff.weight);

   assign m24_sq  = {32'b0, m24_ff} * {32'b0, m24_ff};
   assign v24     = (e24_ff > DVW'(msq_ff)) ? (e24_ff - DVW'(msq_ff)) : '0;
   assign ss_prod = {{WT_BITS{1'b0}}, v12_ff} * {24'b0, n_ff};
   assign num_sum = NSW'(ss_ff) + NSW'({req_ff.prior_beta, 1'b0});
   assign q_sat24 = (div_q[DVW-1:24] != '0) ? 24'hFFFFFF : div_q[23:0];
   assign prior_on = use_prior_ff && (prior_alpha_ff != 16'd0);

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      req_in       = req_ff;
      pair_in      = pair_ff;
      clus_in      = clus_ff;
      wr_in        = wr_ff;
      wrr_in       = wrr_ff;
      s2_in        = s2_ff;
      n_in         = n_ff;
      m24_in       = m24_ff;
      e24_in       = e24_ff;
      msq_in       = msq_ff;
      v12_in       = v12_ff;
      ss_in        = ss_ff;
      mean_in      = mean_ff;
      var_in       = var_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      pram_we      = 1'b0;
      pram_waddr   = pair_ff;
      pram_wdata   = {s2_sum[S2_BITS] ? {S2_BITS{1'b1}} : s2_sum[S2_BITS-1:0],
                      s1_sum[S1_BITS] ? {S1_BITS{1'b1}} : s1_sum[S1_BITS-1:0]};
      wram_we      = 1'b0;
      wram_waddr   = clus_ff;
      wram_wdata   = wt_sum[WT_BITS] ? {WT_BITS{1'b1}} : wt_sum[WT_BITS-1:0];

      div_start    = 1'b0;
      div_dividend = DVW'({s1_cur, 12'b0});
      div_divisor  = DSW'(n_floor);

      unique case (state_ff)
         S_CLEAR: begin
            // Zero one pair entry per cycle; weight entries ride along.
            pram_we    = 1'b1;
            pram_waddr = clr_cnt_ff;
            pram_wdata = '0;
            wram_we    = (32'(clr_cnt_ff) < CLUSTERS);
            wram_waddr = CW'(clr_cnt_ff);
            wram_wdata = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == PW'(PAIRS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in  = req_data;
               pair_in = pair_req;
               clus_in = clus_req;
               wr_in   = {16'b0, req_data.weight} * {13'b0, req_data.reading};
               unique case (req_data.op)
                  OP_CLEAR: begin
                     clr_cnt_in = '0;
                     state_in   = S_CLEAR;
                  end
                  OP_ACCUM: begin
                     if (req_hit) begin
                        state_in = S_ACC1;
                     end
                  end
                  OP_QUERY: begin
                     if (req_hit) begin
                        state_in = S_QRD;
                     end else begin
                        mean_in  = '0;
                        var_in   = '0;
                        state_in = S_DONE;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_ACC1: begin
            wrr_in   = {16'b0, wr_ff} * {29'b0, req_ff.reading};
            state_in = S_ACC2;
         end
         S_ACC2: begin
            pram_we  = 1'b1;
            wram_we  = req_ff.add_weight;
            state_in = S_IDLE;
         end
         S_QRD: begin
            // Mean in Q.12 first: (sum1 << 12) / n.
            s2_in     = s2_cur;
            n_in      = n_floor;
            div_start = 1'b1;
            state_in  = S_QDIV1;
         end
         S_QDIV1: begin
            div_dividend = DVW'(s2_ff);
            div_divisor  = DSW'(n_ff);
            if (div_done) begin
               mean_in   = (div_q[DVW-1:28] != '0) ? 16'hFFFF : div_q[27:12];
               m24_in    = (div_q[DVW-1:32] != '0) ? 32'hFFFFFFFF : div_q[31:0];
               div_start = 1'b1;
               state_in  = S_QDIV2;
            end
         end
         S_QDIV2: begin
            if (div_done) begin
               e24_in   = div_q;
               state_in = S_QMSQ;
            end
         end
         S_QMSQ: begin
            msq_in   = m24_sq[63:24];
            state_in = S_QVAR;
         end
         S_QVAR: begin
            v12_in   = (v24[DVW-1:36] != '0) ? 24'hFFFFFF : v24[35:12];
            state_in = S_QSS;
         end
         S_QSS: begin
            if (prior_on) begin
               ss_in    = ss_prod[WT_BITS+23:12];
               state_in = S_QNUM;
            end else begin
               var_in   = (v12_ff < min_variance_ff) ? min_variance_ff : v12_ff;
               state_in = S_DONE;
            end
         end
         S_QNUM: begin
            // MAP form: ((SS + 2*beta) << 12) / (n + 2*(alpha*16 + 4096)).
            div_start    = 1'b1;
            div_dividend = DVW'({num_sum, 12'b0});
            div_divisor  = DSW'(n_ff) + DSW'({prior_alpha_ff, 5'b0}) + DSW'(14'h2000);
            state_in     = S_QDIV3;
         end
         S_QDIV3: begin
            if (div_done) begin
               var_in   = (q_sat24 < min_variance_ff) ? min_variance_ff : q_sat24;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // Load the result register once the previous result has left.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{mean: mean_ff, variance: var_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_CLEAR;
         clr_cnt_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
         min_variance_ff <= 24'd1;
         use_prior_ff    <= 1'b0;
         prior_alpha_ff  <= 16'd0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_MIN_VARIANCE: min_variance_ff <= csr_wdata;
               CSR_USE_PRIOR:    use_prior_ff    <= csr_wdata[0];
               CSR_PRIOR_ALPHA:  prior_alpha_ff  <= csr_wdata[15:0];
               default:          min_variance_ff <= min_variance_ff;
            endcase
         end
      end
      req_ff      <= req_in;
      pair_ff     <= pair_in;
      clus_ff     <= clus_in;
      wr_ff       <= wr_in;
      wrr_ff      <= wrr_in;
      s2_ff       <= s2_in;
      n_ff        <= n_in;
      m24_ff      <= m24_in;
      e24_ff      <= e24_in;
      msq_ff      <= msq_in;
      v12_ff      <= v12_in;
      ss_ff       <= ss_in;
      mean_ff     <= mean_in;
      var_ff      <= var_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== dv/weighted_mean_variance_accumulator_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Weighted mean / variance accumulator testbench
// Drives clear, accumulate and query requests with random idle gaps on both
// channels, predicts every query result from a local copy of the sums and the
// registers, and compares the results field by field in order.
// ---------------------------------------------------------------------------
module weighted_mean_variance_accumulator_tb;
   import wmva_pkg::*;

   localparam int NUM_CLUSTERS = 8;
   localparam int NUM_FEATURES = 8;
   localparam int COUNT_BITS   = 16;
   localparam int WT_W         = 13 + COUNT_BITS;
   localparam int S1_W         = 28 + COUNT_BITS;
   localparam int S2_W         = 44 + COUNT_BITS;
   localparam logic [63:0] VAR_FULL = 64'hFF_FFFF;
   localparam logic [1:0] OP_SPARE = 2'd3;
   localparam int ITEM_TARGET  = 1350;
   // The slowest query uses the prior form; give ample room.
   localparam longint CYCLE_LIMIT = 1_500_000;
   localparam int DRAIN_CYCLES = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [23:0] csr_wdata = '0;

   weighted_mean_variance_accumulator #(
      .CLUSTERS(NUM_CLUSTERS), .FEATURES(NUM_FEATURES), .SAMPLE_COUNT_BITS(COUNT_BITS)
   ) i_dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predictor state: sums and register copies.
   logic [63:0] weight_sum   [NUM_CLUSTERS];
   logic [63:0] moment1_sum  [NUM_CLUSTERS*NUM_FEATURES];
   logic [63:0] moment2_sum  [NUM_CLUSTERS*NUM_FEATURES];
   logic [23:0] floor_var;
   logic        prior_on;
   logic [15:0] alpha_q88;

   req_type     pending_reqs[$];
   rsp_type     expected_stats[$];
   int          errors = 0;
   int          queries_seen = 0;
   int          accepted = 0;
   longint      cycle_count = 0;
   bit          quiet_phase = 0;   // long stretch with no idling
   bit          driving_done = 0;

   function automatic logic [63:0] add_capped(logic [63:0] cur, logic [63:0] inc, int bits);
      logic [63:0] lim;
      lim = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - bits);
      if (cur > lim) cur = lim;
      if (inc > lim - cur) return lim;
      return cur + inc;
   endfunction

   function automatic void clear_moments();
      foreach (weight_sum[i]) weight_sum[i] = '0;
      foreach (moment1_sum[i]) begin
         moment1_sum[i] = '0;
         moment2_sum[i] = '0;
      end
   endfunction

   // Update the sums for one request; return 1 with the expected stats for a query.
   function automatic bit predict_stats(req_type rq, output rsp_type res);
      logic [63:0] n, s1, s2, mn, m24, e24, msq, v24, v12, vr, ss, den, num, wr, wrr;
      int idx;
      idx = rq.cluster * NUM_FEATURES + rq.feature;
      res = '0;
      case (rq.op)
         OP_CLEAR: begin
            clear_moments();
            return 0;
         end
         OP_ACCUM: begin
            wr  = 64'(rq.weight) * 64'(rq.reading);
            wrr = wr * 64'(rq.reading);
            moment1_sum[idx] = add_capped(moment1_sum[idx], wr, S1_W);
            moment2_sum[idx] = add_capped(moment2_sum[idx], wrr, S2_W);
            if (rq.add_weight)
               weight_sum[rq.cluster] = add_capped(weight_sum[rq.cluster], 64'(rq.weight), WT_W);
            return 0;
         end
         OP_QUERY: begin
            n = weight_sum[rq.cluster];
            if (n < 1) n = 1;
            s1 = moment1_sum[idx];
            s2 = moment2_sum[idx];
            mn = s1 / n;
            if (mn > 64'hFFFF) mn = 64'hFFFF;
            m24 = (s1 << 12) / n;
            if (m24 > 64'hFFFF_FFFF) m24 = 64'hFFFF_FFFF;
            e24 = s2 / n;
            msq = (m24 * m24) >> 24;
            v24 = (e24 > msq) ? e24 - msq : 64'd0;
            v12 = v24 >> 12;
            if (v12 > VAR_FULL) v12 = VAR_FULL;
            if (prior_on && alpha_q88 != 0) begin
               ss  = (v12 * n) >> 12;
               den = n + 2 * (64'(alpha_q88) * 16 + 4096);
               num = (ss + 2 * 64'(rq.prior_beta)) << 12;
               vr  = num / den;
               if (vr > VAR_FULL) vr = VAR_FULL;
            end else begin
               vr = v12;
            end
            if (vr < 64'(floor_var)) vr = 64'(floor_var);
            res.mean = mn[15:0];
            res.variance = vr[23:0];
            return 1;
         end
         default: return 0;
      endcase
   endfunction

   function automatic req_type make_req(logic [1:0] op, int c, int f, int w, int r,
                                        bit aw, int beta);
      req_type rq;
      rq.op = op;
      rq.cluster = c[2:0];
      rq.feature = f[2:0];
      rq.weight = w[12:0];
      rq.reading = r[15:0];
      rq.add_weight = aw;
      rq.prior_beta = beta[23:0];
      return rq;
   endfunction

   function automatic req_type rand_req(logic [1:0] op);
      int w;
      // Mostly weights up to 4096; the odd weight from the full range up to 8191.
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 4096);
      return make_req(op, $urandom_range(0, 7), $urandom_range(0, 7), w,
                      $urandom_range(0, 65535), $urandom_range(0, 1),
                      ($urandom_range(0, 3) == 0) ? 24'hFF_FFFF : $urandom_range(0, 24'hFF_FFFF));
   endfunction

   // Driver: takes the next pending request when not idling; holds it while stalled.
   always @(posedge clock) begin
      rsp_type predicted;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            accepted <= accepted + 1;
            if (predict_stats(req_data, predicted)) begin
               expected_stats.push_back(predicted);
            end
         end
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() > 0 && (quiet_phase || $urandom_range(0, 99) >= 38)) begin
               req_data  <= pending_reqs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compares each result with the oldest expectation.
   always @(posedge clock) begin
      rsp_stall <= quiet_phase ? 1'b0 : ($urandom_range(0, 99) < 38);
      if (!reset && rsp_valid && !rsp_stall) begin
         queries_seen <= queries_seen + 1;
         if (expected_stats.size() == 0) begin
            $display("%0t: unexpected result mean=%h variance=%h", $time, rsp_data.mean,
                     rsp_data.variance);
            errors = errors + 1;
         end else begin
            rsp_type ex;
            ex = expected_stats.pop_front();
            if (ex.mean !== rsp_data.mean) begin
               $display("%0t: mean expected %h actual %h", $time, ex.mean, rsp_data.mean);
               errors = errors + 1;
            end
            if (ex.variance !== rsp_data.variance) begin
               $display("%0t: variance expected %h actual %h", $time, ex.variance,
                        rsp_data.variance);
               errors = errors + 1;
            end
         end
      end
   end

   // Watchdog over the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [23:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_MIN_VARIANCE: floor_var = val;
         CSR_USE_PRIOR:    prior_on  = val[0];
         CSR_PRIOR_ALPHA:  alpha_q88 = val[15:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Wait until every queued request went out and every result came back.
   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || expected_stats.size() > 0)
         @(posedge clock);
      // Accumulates and clears give no result and may still be in flight.
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One random phase: mostly accumulates mixed with queries, some clears and spare ops.
   task automatic random_phase(int count);
      int k;
      req_type rq;
      k = 0;
      while (k < count) begin
         int pick;
         pick = $urandom_range(0, 99);
         if (pick < 70) rq = rand_req(OP_ACCUM);
         else if (pick < 92) rq = rand_req(OP_QUERY);
         else if (pick < 95) rq = rand_req(OP_CLEAR);
         else rq = rand_req(OP_SPARE);
         pending_reqs.push_back(rq);
         if (rq.op != OP_SPARE) k++;
      end
   endtask

   initial begin
      floor_var = 24'd1;
      prior_on  = 1'b0;
      alpha_q88 = '0;
      clear_moments();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty cluster, extremes, every op, unused op, weights over one.
      pending_reqs.push_back(make_req(OP_QUERY, 0, 0, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_ACCUM, 7, 7, 8191, 65535, 1, 24'hFF_FFFF));
      pending_reqs.push_back(make_req(OP_QUERY, 7, 7, 0, 0, 0, 24'hFF_FFFF));
      pending_reqs.push_back(make_req(OP_ACCUM, 3, 5, 4096, 4096, 0, 0));
      pending_reqs.push_back(make_req(OP_QUERY, 3, 5, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_ACCUM, 3, 5, 2048, 8192, 1, 0));
      pending_reqs.push_back(make_req(OP_ACCUM, 3, 5, 2048, 12288, 1, 0));
      pending_reqs.push_back(make_req(OP_QUERY, 3, 5, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_SPARE, 3, 5, 100, 100, 1, 5));
      pending_reqs.push_back(make_req(OP_ACCUM, 0, 1, 1, 1, 1, 0));
      pending_reqs.push_back(make_req(OP_QUERY, 0, 1, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_CLEAR, 0, 0, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_QUERY, 7, 7, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_QUERY, 3, 5, 0, 0, 0, 0));
      drain();

      // Register settings per phase, extremes included.
      csr_write(CSR_MIN_VARIANCE, 24'd0);
      csr_write(CSR_USE_PRIOR, 24'd1);
      csr_write(CSR_PRIOR_ALPHA, 24'hFFFF);
      random_phase(200);
      drain();
      csr_write(CSR_MIN_VARIANCE, 24'hFF_FFFF);
      csr_write(CSR_PRIOR_ALPHA, 24'd1);
      random_phase(150);
      drain();
      csr_write(CSR_USE_PRIOR, 24'd0);
      csr_write(CSR_MIN_VARIANCE, 24'd300);
      quiet_phase = 1;
      random_phase(300);
      drain();
      quiet_phase = 0;
      csr_write(CSR_USE_PRIOR, 24'd1);
      csr_write(CSR_PRIOR_ALPHA, 24'd0);
      random_phase(200);
      drain();
      csr_write(CSR_PRIOR_ALPHA, 24'($urandom_range(1, 65535)));
      csr_write(CSR_MIN_VARIANCE, 24'($urandom_range(0, 4096)));
      random_phase(480);
      drain();

      $display("Sent %0d requests; %0d query results checked across six register settings.",
               accepted, queries_seen);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
